// ===== rtl/core/grc_pkg.sv =====
// Shared constants and control types for the grid region counter.
`default_nettype none
package grc_pkg;

    localparam int COORD_W = 7;
    localparam int COVER_W = 7;
    localparam int COUNT_W = 13;

    localparam logic CFG_ROWS = 1'b0;
    localparam logic CFG_COLS = 1'b1;

    localparam logic signed [1:0] STEP_ROW [4] = '{2'sd0, 2'sd0, 2'sd1, -2'sd1};
    localparam logic signed [1:0] STEP_COL [4] = '{2'sd1, -2'sd1, 2'sd0, 2'sd0};

    typedef struct packed {
        logic unite;
        logic clear;
    } uf_cmd_t;

    typedef struct packed {
        logic idle;
        logic done;
        logic merged;
    } uf_stat_t;

endpackage
`default_nettype wire

// ===== rtl/core/grid_region_count_after_paints_core.sv =====
// Top level: rectangle loader, coverage memory, region count sequencer and result port.
//
// Each rectangle is painted by a read-modify-write of the coverage memory
// for every covered cell. The final rectangle then runs the count: a pass
// over the grid counts free cells, then a join pass visits each free cell,
// skips each neighbor outside the grid, checks each neighbor inside it and,
// for each free neighbor, runs a union-find operation. Then, for each stored
// rectangle in reverse, it fetches the rectangle, uncovers each covered cell
// and runs a join pass over the same cells. Results then leave one at a time,
// each held until the receiver is ready. After reset and after each run a
// clearing pass over all 2^(2*ceil(log2(GRID_SIDE))) entries (4096 by default)
// resets the coverage and parent-link memories; no item is taken during it.
`default_nettype none
module grid_region_count_after_paints_core #(
    parameter int GRID_SIDE = 64,
    parameter int MAX_RECTS = 64
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_valid,
    output      logic                          cfg_ready,
    input  wire logic                          cfg_index,
    input  wire logic [grc_pkg::COORD_W-1:0]   cfg_data,
    input  wire logic                          in_valid,
    output      logic                          in_ready,
    input  wire logic [grc_pkg::COORD_W-1:0]   row_low,
    input  wire logic [grc_pkg::COORD_W-1:0]   col_low,
    input  wire logic [grc_pkg::COORD_W-1:0]   row_high,
    input  wire logic [grc_pkg::COORD_W-1:0]   col_high,
    input  wire logic                          final_rect,
    output      logic                          out_valid,
    input  wire logic                          out_ready,
    output      logic [grc_pkg::COUNT_W-1:0]   region_count,
    output      logic [grc_pkg::COORD_W-1:0]   rect_index,
    output      logic                          final_result
);
    import grc_pkg::*;

    localparam int SW  = $clog2(GRID_SIDE);
    localparam int AW  = 2 * SW;
    localparam int LW  = AW + 1;
    localparam int RIW = (MAX_RECTS > 1) ? $clog2(MAX_RECTS) : 1;
    localparam int TW  = $clog2(MAX_RECTS + 1);
    localparam int RW  = 4 * SW;

    typedef enum logic [4:0] {
        S_CLEAR, S_CLR_WAIT, S_IDLE, S_P_RD, S_P_WR, S_C_RD, S_C_CHK,
        S_J_RD, S_J_CHK, S_J_NB, S_J_NCHK, S_J_UF, S_K_RD, S_K_LD,
        S_D_RD, S_D_WR, S_E_RD, S_E_LD, S_E_WAIT
    } state_t;

    typedef enum logic {PH_ALL, PH_RECT} phase_t;

    function automatic logic [SW-1:0] clamp_side(input logic [COORD_W-1:0] v);
        logic [SW-1:0] res;
        if (v == '0)
            res = '0;
        else if (32'(v) > GRID_SIDE)
            res = SW'(GRID_SIDE - 1);
        else
            res = SW'(v - 1'b1);
        return res;
    endfunction

    state_t               state_reg;
    phase_t               phase_reg;
    logic [COORD_W-1:0]   rows_reg;
    logic [COORD_W-1:0]   cols_reg;
    logic [TW-1:0]        total_reg;
    logic [LW-1:0]        live_reg;
    logic                 fin_reg;
    logic [SW-1:0]        cur_r_reg;
    logic [SW-1:0]        cur_c_reg;
    logic [SW-1:0]        lo_r_reg;
    logic [SW-1:0]        hi_r_reg;
    logic [SW-1:0]        lo_c_reg;
    logic [SW-1:0]        hi_c_reg;
    logic [1:0]           dir_reg;
    logic [AW-1:0]        nb_reg;
    logic [RIW-1:0]       k_reg;
    logic [TW-1:0]        i_reg;
    logic [AW-1:0]        clr_cnt_reg;
    logic                 out_valid_reg;
    logic [COUNT_W-1:0]   region_count_reg;
    logic [COORD_W-1:0]   rect_index_reg;
    logic                 final_result_reg;

    logic [COVER_W-1:0]   cover_mem [2**AW];
    logic [COVER_W-1:0]   cov_q;
    logic [RW-1:0]        rect_mem [MAX_RECTS];
    logic [RW-1:0]        rect_q;
    logic [COUNT_W-1:0]   prefix_mem [MAX_RECTS];
    logic [COUNT_W-1:0]   prefix_q;

    logic [SW-1:0]        nr_m1;
    logic [SW-1:0]        nc_m1;
    logic [SW-1:0]        in_rl;
    logic [SW-1:0]        in_cl;
    logic [SW-1:0]        in_rh;
    logic [SW-1:0]        in_ch;
    logic                 in_take;
    logic                 store_ok;
    logic [AW-1:0]        cur_id;
    logic                 cur_in;
    logic                 last_cell;
    logic [SW:0]          nb_r;
    logic [SW:0]          nb_c;
    logic                 nb_ok;
    logic [SW-1:0]        q_rl;
    logic [SW-1:0]        q_cl;
    logic [SW-1:0]        q_rh;
    logic [SW-1:0]        q_ch;

    logic                 cov_we;
    logic [AW-1:0]        cov_waddr;
    logic [COVER_W-1:0]   cov_wdata;
    logic [AW-1:0]        cov_raddr;

    uf_cmd_t              uf_cmd;
    uf_stat_t             uf_stat;

    assign nr_m1    = clamp_side(rows_reg);
    assign nc_m1    = clamp_side(cols_reg);
    assign in_rl    = clamp_side(row_low);
    assign in_cl    = clamp_side(col_low);
    assign in_rh    = clamp_side(row_high);
    assign in_ch    = clamp_side(col_high);
    assign in_ready = (state_reg == S_IDLE);
    assign in_take  = in_valid && in_ready;
    assign store_ok = (total_reg < TW'(MAX_RECTS));
    assign cur_id   = {cur_r_reg, cur_c_reg};
    assign cur_in   = (cur_r_reg <= nr_m1) && (cur_c_reg <= nc_m1);
    assign last_cell = (cur_r_reg == hi_r_reg) && (cur_c_reg == hi_c_reg);
    assign nb_r     = {1'b0, cur_r_reg} + {{(SW-1){STEP_ROW[dir_reg][1]}}, STEP_ROW[dir_reg]};
    assign nb_c     = {1'b0, cur_c_reg} + {{(SW-1){STEP_COL[dir_reg][1]}}, STEP_COL[dir_reg]};
    assign nb_ok    = !nb_r[SW] && !nb_c[SW] && (nb_r[SW-1:0] <= nr_m1)
                      && (nb_c[SW-1:0] <= nc_m1);
    assign {q_rl, q_cl, q_rh, q_ch} = rect_q;

    assign cfg_ready    = 1'b1;
    assign out_valid    = out_valid_reg;
    assign region_count = region_count_reg;
    assign rect_index   = rect_index_reg;
    assign final_result = final_result_reg;

    assign uf_cmd.unite = (state_reg == S_J_NCHK) && (cov_q == '0);
    assign uf_cmd.clear = (state_reg == S_E_WAIT) && out_ready && final_result_reg;

    always_comb
    begin
        cov_we    = 1'b0;
        cov_waddr = cur_id;
        cov_wdata = '0;
        cov_raddr = cur_id;
        case (state_reg)
            S_CLEAR:
            begin
                cov_we    = 1'b1;
                cov_waddr = clr_cnt_reg;
            end
            S_P_WR:
            begin
                cov_we    = 1'b1;
                cov_wdata = cov_q + 1'b1;
            end
            S_D_WR:
            begin
                cov_we    = (cov_q != '0);
                cov_wdata = cov_q - 1'b1;
            end
            S_J_NB:
            begin
                cov_raddr = {nb_r[SW-1:0], nb_c[SW-1:0]};
            end
            default:
            begin
                cov_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cov_we)
        begin
            cover_mem[cov_waddr] <= cov_wdata;
        end
        cov_q <= cover_mem[cov_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (in_take && store_ok)
        begin
            rect_mem[total_reg[RIW-1:0]] <= {in_rl, in_cl, in_rh, in_ch};
        end
        rect_q <= rect_mem[k_reg];
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_K_RD)
        begin
            prefix_mem[k_reg] <= COUNT_W'(live_reg);
        end
        prefix_q <= prefix_mem[i_reg[RIW-1:0]];
    end

    grc_uf #(
        .AW (AW)
    ) u_uf (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (uf_cmd),
        .a     (cur_id),
        .b     (nb_reg),
        .stat  (uf_stat)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_CLEAR;
            phase_reg        <= PH_ALL;
            rows_reg         <= COORD_W'((GRID_SIDE > 127) ? 127 : GRID_SIDE);
            cols_reg         <= COORD_W'((GRID_SIDE > 127) ? 127 : GRID_SIDE);
            total_reg        <= '0;
            live_reg         <= '0;
            fin_reg          <= 1'b0;
            cur_r_reg        <= '0;
            cur_c_reg        <= '0;
            lo_r_reg         <= '0;
            hi_r_reg         <= '0;
            lo_c_reg         <= '0;
            hi_c_reg         <= '0;
            dir_reg          <= '0;
            nb_reg           <= '0;
            k_reg            <= '0;
            i_reg            <= '0;
            clr_cnt_reg      <= '0;
            out_valid_reg    <= 1'b0;
            region_count_reg <= '0;
            rect_index_reg   <= '0;
            final_result_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                case (cfg_index)
                    CFG_ROWS: rows_reg <= cfg_data;
                    CFG_COLS: cols_reg <= cfg_data;
                    default:  rows_reg <= rows_reg;
                endcase
            end

            case (state_reg)
                S_CLEAR:
                begin
                    clr_cnt_reg <= clr_cnt_reg + 1'b1;
                    if (&clr_cnt_reg)
                    begin
                        state_reg <= S_CLR_WAIT;
                    end
                end
                S_CLR_WAIT:
                begin
                    if (uf_stat.idle)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        fin_reg <= final_rect;
                        if (store_ok)
                        begin
                            total_reg <= total_reg + 1'b1;
                        end
                        if (store_ok && (in_rl <= in_rh) && (in_cl <= in_ch))
                        begin
                            lo_r_reg  <= in_rl;
                            hi_r_reg  <= in_rh;
                            lo_c_reg  <= in_cl;
                            hi_c_reg  <= in_ch;
                            cur_r_reg <= in_rl;
                            cur_c_reg <= in_cl;
                            state_reg <= S_P_RD;
                        end
                        else if (final_rect)
                        begin
                            live_reg  <= '0;
                            lo_r_reg  <= '0;
                            hi_r_reg  <= nr_m1;
                            lo_c_reg  <= '0;
                            hi_c_reg  <= nc_m1;
                            cur_r_reg <= '0;
                            cur_c_reg <= '0;
                            state_reg <= S_C_RD;
                        end
                    end
                end
                S_P_RD:
                begin
                    state_reg <= S_P_WR;
                end
                S_P_WR:
                begin
                    if (last_cell)
                    begin
                        if (fin_reg)
                        begin
                            live_reg  <= '0;
                            lo_r_reg  <= '0;
                            hi_r_reg  <= nr_m1;
                            lo_c_reg  <= '0;
                            hi_c_reg  <= nc_m1;
                            cur_r_reg <= '0;
                            cur_c_reg <= '0;
                            state_reg <= S_C_RD;
                        end
                        else
                        begin
                            state_reg <= S_IDLE;
                        end
                    end
                    else
                    begin
                        if (cur_c_reg == hi_c_reg)
                        begin
                            cur_c_reg <= lo_c_reg;
                            cur_r_reg <= cur_r_reg + 1'b1;
                        end
                        else
                        begin
                            cur_c_reg <= cur_c_reg + 1'b1;
                        end
                        state_reg <= S_P_RD;
                    end
                end
                S_C_RD:
                begin
                    state_reg <= S_C_CHK;
                end
                S_C_CHK:
                begin
                    if (cov_q == '0)
                    begin
                        live_reg <= live_reg + 1'b1;
                    end
                    if (last_cell)
                    begin
                        cur_r_reg <= '0;
                        cur_c_reg <= '0;
                        phase_reg <= PH_ALL;
                        state_reg <= S_J_RD;
                    end
                    else
                    begin
                        if (cur_c_reg == hi_c_reg)
                        begin
                            cur_c_reg <= lo_c_reg;
                            cur_r_reg <= cur_r_reg + 1'b1;
                        end
                        else
                        begin
                            cur_c_reg <= cur_c_reg + 1'b1;
                        end
                        state_reg <= S_C_RD;
                    end
                end
                S_J_RD:
                begin
                    state_reg <= S_J_CHK;
                end
                S_J_CHK, S_J_NB, S_J_NCHK, S_J_UF:
                begin
                    logic cell_done;
                    cell_done = 1'b0;
                    if (state_reg == S_J_CHK)
                    begin
                        if (!cur_in || (cov_q != '0))
                        begin
                            cell_done = 1'b1;
                        end
                        else
                        begin
                            dir_reg   <= '0;
                            state_reg <= S_J_NB;
                        end
                    end
                    else if (state_reg == S_J_NB)
                    begin
                        if (nb_ok)
                        begin
                            nb_reg    <= {nb_r[SW-1:0], nb_c[SW-1:0]};
                            state_reg <= S_J_NCHK;
                        end
                        else if (dir_reg == 2'd3)
                        begin
                            cell_done = 1'b1;
                        end
                        else
                        begin
                            dir_reg <= dir_reg + 1'b1;
                        end
                    end
                    else if (state_reg == S_J_NCHK)
                    begin
                        if (cov_q == '0)
                        begin
                            state_reg <= S_J_UF;
                        end
                        else if (dir_reg == 2'd3)
                        begin
                            cell_done = 1'b1;
                        end
                        else
                        begin
                            dir_reg   <= dir_reg + 1'b1;
                            state_reg <= S_J_NB;
                        end
                    end
                    else if (uf_stat.done)
                    begin
                        if (uf_stat.merged && (live_reg != '0))
                        begin
                            live_reg <= live_reg - 1'b1;
                        end
                        if (dir_reg == 2'd3)
                        begin
                            cell_done = 1'b1;
                        end
                        else
                        begin
                            dir_reg   <= dir_reg + 1'b1;
                            state_reg <= S_J_NB;
                        end
                    end

                    if (cell_done)
                    begin
                        if (!last_cell)
                        begin
                            if (cur_c_reg == hi_c_reg)
                            begin
                                cur_c_reg <= lo_c_reg;
                                cur_r_reg <= cur_r_reg + 1'b1;
                            end
                            else
                            begin
                                cur_c_reg <= cur_c_reg + 1'b1;
                            end
                            state_reg <= S_J_RD;
                        end
                        else if (phase_reg == PH_ALL)
                        begin
                            k_reg     <= RIW'(total_reg - 1'b1);
                            state_reg <= S_K_RD;
                        end
                        else if (k_reg == '0)
                        begin
                            i_reg     <= '0;
                            state_reg <= S_E_RD;
                        end
                        else
                        begin
                            k_reg     <= k_reg - 1'b1;
                            state_reg <= S_K_RD;
                        end
                    end
                end
                S_K_RD:
                begin
                    state_reg <= S_K_LD;
                end
                S_K_LD:
                begin
                    if ((q_rl <= q_rh) && (q_cl <= q_ch))
                    begin
                        lo_r_reg  <= q_rl;
                        hi_r_reg  <= q_rh;
                        lo_c_reg  <= q_cl;
                        hi_c_reg  <= q_ch;
                        cur_r_reg <= q_rl;
                        cur_c_reg <= q_cl;
                        state_reg <= S_D_RD;
                    end
                    else if (k_reg == '0)
                    begin
                        i_reg     <= '0;
                        state_reg <= S_E_RD;
                    end
                    else
                    begin
                        k_reg     <= k_reg - 1'b1;
                        state_reg <= S_K_RD;
                    end
                end
                S_D_RD:
                begin
                    state_reg <= S_D_WR;
                end
                S_D_WR:
                begin
                    if ((cov_q == COVER_W'(1)) && cur_in)
                    begin
                        live_reg <= live_reg + 1'b1;
                    end
                    if (last_cell)
                    begin
                        cur_r_reg <= lo_r_reg;
                        cur_c_reg <= lo_c_reg;
                        phase_reg <= PH_RECT;
                        state_reg <= S_J_RD;
                    end
                    else
                    begin
                        if (cur_c_reg == hi_c_reg)
                        begin
                            cur_c_reg <= lo_c_reg;
                            cur_r_reg <= cur_r_reg + 1'b1;
                        end
                        else
                        begin
                            cur_c_reg <= cur_c_reg + 1'b1;
                        end
                        state_reg <= S_D_RD;
                    end
                end
                S_E_RD:
                begin
                    state_reg <= S_E_LD;
                end
                S_E_LD:
                begin
                    out_valid_reg    <= 1'b1;
                    region_count_reg <= prefix_q;
                    rect_index_reg   <= COORD_W'(i_reg) + 1'b1;
                    final_result_reg <= (TW'(i_reg + 1'b1) == total_reg);
                    state_reg        <= S_E_WAIT;
                end
                S_E_WAIT:
                begin
                    if (out_ready)
                    begin
                        out_valid_reg <= 1'b0;
                        if (final_result_reg)
                        begin
                            total_reg   <= '0;
                            live_reg    <= '0;
                            fin_reg     <= 1'b0;
                            clr_cnt_reg <= '0;
                            state_reg   <= S_CLEAR;
                        end
                        else
                        begin
                            i_reg     <= i_reg + 1'b1;
                            state_reg <= S_E_RD;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule
`default_nettype wire

// ===== rtl/core/grc_uf.sv =====
// Union-find unit: parent-link memory, find with path compression, link, clear sweep.
`default_nettype none
module grc_uf #(
    parameter int AW = 12
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire grc_pkg::uf_cmd_t  cmd,
    input  wire logic [AW-1:0]     a,
    input  wire logic [AW-1:0]     b,
    output grc_pkg::uf_stat_t      stat
);
    import grc_pkg::*;

    typedef enum logic [2:0] {
        U_CLEAR, U_IDLE, U_FRD, U_FCHK, U_CRD, U_CCHK, U_LINK, U_DONE
    } uf_state_t;

    uf_state_t       state_reg;
    logic [AW-1:0]   cnt_reg;
    logic [AW-1:0]   cur_reg;
    logic [AW-1:0]   start_reg;
    logic [AW-1:0]   b_reg;
    logic [AW-1:0]   root_reg;
    logic [AW-1:0]   root_a_reg;
    logic            second_reg;
    logic            merged_reg;

    logic [AW-1:0]   link_mem [2**AW];
    logic [AW-1:0]   q_reg;
    logic            we;
    logic [AW-1:0]   waddr;
    logic [AW-1:0]   wdata;

    always_comb
    begin
        we    = 1'b0;
        waddr = cur_reg;
        wdata = root_reg;
        case (state_reg)
            U_CLEAR:
            begin
                we    = 1'b1;
                waddr = cnt_reg;
                wdata = cnt_reg;
            end
            U_CCHK:
            begin
                we = (q_reg != root_reg);
            end
            U_LINK:
            begin
                we    = 1'b1;
                waddr = root_a_reg;
            end
            default:
            begin
                we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            link_mem[waddr] <= wdata;
        end
        q_reg <= link_mem[cur_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= U_CLEAR;
            cnt_reg    <= '0;
            cur_reg    <= '0;
            start_reg  <= '0;
            b_reg      <= '0;
            root_reg   <= '0;
            root_a_reg <= '0;
            second_reg <= 1'b0;
            merged_reg <= 1'b0;
        end
        else
        begin
            case (state_reg)
                U_CLEAR:
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (&cnt_reg)
                    begin
                        state_reg <= U_IDLE;
                    end
                end
                U_IDLE:
                begin
                    if (cmd.clear)
                    begin
                        cnt_reg   <= '0;
                        state_reg <= U_CLEAR;
                    end
                    else if (cmd.unite)
                    begin
                        cur_reg    <= a;
                        start_reg  <= a;
                        b_reg      <= b;
                        second_reg <= 1'b0;
                        state_reg  <= U_FRD;
                    end
                end
                U_FRD:
                begin
                    state_reg <= U_FCHK;
                end
                U_FCHK:
                begin
                    if (q_reg == cur_reg)
                    begin
                        root_reg  <= cur_reg;
                        cur_reg   <= start_reg;
                        state_reg <= U_CRD;
                    end
                    else
                    begin
                        cur_reg   <= q_reg;
                        state_reg <= U_FRD;
                    end
                end
                U_CRD:
                begin
                    state_reg <= U_CCHK;
                end
                U_CCHK:
                begin
                    if (q_reg == root_reg)
                    begin
                        if (!second_reg)
                        begin
                            root_a_reg <= root_reg;
                            second_reg <= 1'b1;
                            cur_reg    <= b_reg;
                            start_reg  <= b_reg;
                            state_reg  <= U_FRD;
                        end
                        else if (root_a_reg == root_reg)
                        begin
                            merged_reg <= 1'b0;
                            state_reg  <= U_DONE;
                        end
                        else
                        begin
                            state_reg <= U_LINK;
                        end
                    end
                    else
                    begin
                        cur_reg   <= q_reg;
                        state_reg <= U_CRD;
                    end
                end
                U_LINK:
                begin
                    merged_reg <= 1'b1;
                    state_reg  <= U_DONE;
                end
                U_DONE:
                begin
                    state_reg <= U_IDLE;
                end
                default:
                begin
                    state_reg <= U_IDLE;
                end
            endcase
        end
    end

    assign stat.idle   = (state_reg == U_IDLE);
    assign stat.done   = (state_reg == U_DONE);
    assign stat.merged = merged_reg;

endmodule
`default_nettype wire
